// ----- design/nws_pkg.sv -----
// ----------------------------------------------------------------------------
// nws_pkg: shared types and constants of the NACK window send scheduler
// Request and result layouts, result kinds, register indexes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nws_pkg;

	localparam int SEQ_BITS   = 16;
	localparam int CNT_W      = SEQ_BITS + 1;
	localparam int TIME_W     = 32;
	localparam int TAG_W      = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int WINDOW_DEF = 32;

	localparam logic [CFG_W-1:0] TIMEOUT_RST   = CFG_W'(300);
	localparam logic [CFG_W-1:0] TAIL_WAIT_RST = CFG_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TIMEOUT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_WAIT      = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		KIND_NEW    = 2'd0,
		KIND_NACK   = 2'd1,
		KIND_TAIL   = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_POLL  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [TAG_W-1:0]    file_tag;
		logic [CNT_W-1:0]    chunk_count;
		logic [TIME_W-1:0]   now_ms;
		logic                nack_valid;
		logic [SEQ_BITS-1:0] nack_seq;
	} req_item_t;

	typedef struct packed {
		kind_t               kind;
		logic [SEQ_BITS-1:0] seq;
		logic [TAG_W-1:0]    tag_out;
		logic [CNT_W-1:0]    count_out;
		logic                done_res;
		logic                last;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ISSUE,
		ST_NACK,
		ST_SLIDE_RD,
		ST_SLIDE_CMP,
		ST_TAIL_RD,
		ST_TAIL_CMP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic start;
		logic issue;
		logic nack_emit;
		logic rd_base;
		logic slide;
		logic rd_last;
		logic tail_emit;
		logic status_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_start;
		logic active;
		logic can_issue;
		logic nack_ok;
		logic base_lt_next;
		logic timed_out;
		logic tail_full;
		logic tail_old;
	} dp_status_t;

endpackage

// ----- design/nws_ctrl.sv -----
// ----------------------------------------------------------------------------
// nws_ctrl: sequencing controller
// Walks each poll on an open transfer through issue, nack, slide and tail
// phases; every request ends with a status result. Drives the datapath by command bits only.
// ----------------------------------------------------------------------------
module nws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  nws_pkg::dp_status_t sts,
	output nws_pkg::ctrl_cmd_t  cmd
);
	import nws_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   status_q;
	logic   status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	// status_q marks the closing status result still owed before the next request is accepted
	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (status_q) begin
					if (sts.out_free) begin
						cmd.status_emit = 1'b1;
						status_d        = 1'b0;
					end
				end else begin
					req_ready = 1'b1;
					if (req_valid) begin
						cmd.load_in = 1'b1;
						state_d     = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				if (sts.is_start) begin
					cmd.start = 1'b1;
					status_d  = 1'b1;
					state_d   = ST_IDLE;
				end else if (sts.active) begin
					state_d = ST_ISSUE;
				end else begin
					status_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_ISSUE: begin
				if (!sts.can_issue) begin
					state_d = ST_NACK;
				end else if (sts.out_free) begin
					cmd.issue = 1'b1;
				end
			end
			ST_NACK: begin
				if (!sts.nack_ok) begin
					state_d = ST_SLIDE_RD;
				end else if (sts.out_free) begin
					cmd.nack_emit = 1'b1;
					state_d       = ST_SLIDE_RD;
				end
			end
			ST_SLIDE_RD: begin
				if (sts.base_lt_next) begin
					cmd.rd_base = 1'b1;
					state_d     = ST_SLIDE_CMP;
				end else begin
					state_d = ST_TAIL_RD;
				end
			end
			ST_SLIDE_CMP: begin
				if (sts.timed_out) begin
					cmd.slide = 1'b1;
					state_d   = ST_SLIDE_RD;
				end else begin
					state_d = ST_TAIL_RD;
				end
			end
			ST_TAIL_RD: begin
				if (sts.tail_full) begin
					cmd.rd_last = 1'b1;
					state_d     = ST_TAIL_CMP;
				end else begin
					status_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_TAIL_CMP: begin
				if (!sts.tail_old) begin
					status_d = 1'b1;
					state_d  = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.tail_emit = 1'b1;
					status_d      = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- design/nws_dp.sv -----
// ----------------------------------------------------------------------------
// nws_dp: window datapath
// Transfer state, configuration registers, send stamp memory with one
// registered read port, age compares and the result register.
// ----------------------------------------------------------------------------
module nws_dp #(
	parameter int WINDOW = nws_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nws_pkg::req_item_t             req_item,
	input  logic                           cfg_we,
	input  logic [nws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nws_pkg::CFG_W-1:0]      cfg_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output nws_pkg::res_item_t             res_item,
	input  nws_pkg::ctrl_cmd_t             cmd,
	output nws_pkg::dp_status_t            sts
);
	import nws_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W:0]   WIN_SUM   = (IDX_W + 1)'(WINDOW);
	localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WINDOW);
	localparam logic [CNT_W-1:0] MAX_COUNT = {1'b1, {SEQ_BITS{1'b0}}};

	logic [CFG_W-1:0]    timeout_q;
	logic [CFG_W-1:0]    tail_wait_q;
	logic [CNT_W-1:0]    base_q;
	logic [CNT_W-1:0]    next_q;
	logic [CNT_W-1:0]    total_q;
	logic [TAG_W-1:0]    tag_q;
	logic                active_q;
	logic [IDX_W-1:0]    base_slot_q;
	logic [IDX_W-1:0]    next_slot_q;
	req_item_t           req_q;
	logic [TIME_W-1:0]   stamp_mem [WINDOW];
	logic [TIME_W-1:0]   rdata_q;
	logic                res_valid_q;
	res_item_t           res_q;

	logic [CNT_W-1:0]    win_used;
	logic [CNT_W-1:0]    nack_ext;
	logic [CNT_W-1:0]    nack_diff;
	logic [IDX_W:0]      nack_sum;
	logic [IDX_W:0]      nack_wrap;
	logic [IDX_W-1:0]    nack_slot;
	logic                nack_in_win;
	logic [IDX_W-1:0]    last_slot;
	logic [IDX_W-1:0]    base_slot_inc;
	logic [IDX_W-1:0]    next_slot_inc;
	logic [CNT_W-1:0]    start_count;
	logic [TIME_W-1:0]   age;
	logic                out_free;
	logic                out_load;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [IDX_W-1:0]    raddr;
	res_item_t           res_d;

	assign win_used      = next_q - base_q;
	assign nack_ext      = {1'b0, req_q.nack_seq};
	assign nack_diff     = nack_ext - base_q;
	assign nack_sum      = {1'b0, base_slot_q} + {1'b0, nack_diff[IDX_W-1:0]};
	assign nack_wrap     = nack_sum - WIN_SUM;
	assign nack_slot     = (nack_sum >= WIN_SUM) ? nack_wrap[IDX_W-1:0] : nack_sum[IDX_W-1:0];
	assign nack_in_win   = (nack_ext >= base_q) && (nack_ext < next_q);
	assign last_slot     = (next_slot_q == '0) ? SLOT_LAST : next_slot_q - IDX_W'(1);
	assign base_slot_inc = (base_slot_q == SLOT_LAST) ? '0 : base_slot_q + IDX_W'(1);
	assign next_slot_inc = (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + IDX_W'(1);
	assign age           = req_q.now_ms - rdata_q;

	always_comb begin
		start_count = req_q.chunk_count;
		if (start_count == '0) begin
			start_count = CNT_W'(1);
		end else if (start_count > MAX_COUNT) begin
			start_count = MAX_COUNT;
		end
	end

	assign out_free = !res_valid_q || res_ready;
	assign out_load = cmd.issue || cmd.nack_emit || cmd.tail_emit || cmd.status_emit;

	assign sts.out_free     = out_free;
	assign sts.is_start     = (req_q.cmd == CMD_START);
	assign sts.active       = active_q;
	assign sts.can_issue    = (win_used < WIN_CNT) && (next_q < total_q);
	assign sts.nack_ok      = req_q.nack_valid && (nack_ext < total_q);
	assign sts.base_lt_next = (base_q < next_q);
	assign sts.timed_out    = (age > {{(TIME_W - CFG_W){1'b0}}, timeout_q});
	assign sts.tail_full    = (next_q == total_q);
	assign sts.tail_old     = (age > {{(TIME_W - CFG_W){1'b0}}, tail_wait_q});

	always_comb begin
		res_d           = '0;
		res_d.tag_out   = tag_q;
		res_d.count_out = total_q;
		res_d.kind      = KIND_STATUS;
		res_d.seq       = base_q[SEQ_BITS-1:0];
		if (cmd.issue) begin
			res_d.kind = KIND_NEW;
			res_d.seq  = next_q[SEQ_BITS-1:0];
		end else if (cmd.nack_emit) begin
			res_d.kind = KIND_NACK;
			res_d.seq  = req_q.nack_seq;
		end else if (cmd.tail_emit) begin
			res_d.kind = KIND_TAIL;
			res_d.seq  = next_q[SEQ_BITS-1:0] - SEQ_BITS'(1);
		end else begin
			res_d.done_res = (base_q == total_q);
			res_d.last     = 1'b1;
		end
	end

	always_comb begin
		we    = cmd.issue || (cmd.nack_emit && nack_in_win) || cmd.tail_emit;
		waddr = next_slot_q;
		if (cmd.nack_emit) begin
			waddr = nack_slot;
		end else if (cmd.tail_emit) begin
			waddr = last_slot;
		end
		raddr = cmd.rd_last ? last_slot : base_slot_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stamp_mem[waddr] <= req_q.now_ms;
		end
		if (cmd.rd_base || cmd.rd_last) begin
			rdata_q <= stamp_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req_item;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			tail_wait_q <= TAIL_WAIT_RST;
			base_q      <= '0;
			next_q      <= '0;
			total_q     <= CNT_W'(1);
			tag_q       <= '0;
			active_q    <= 1'b0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_TIMEOUT: timeout_q   <= cfg_data;
					REG_TAIL_WAIT:      tail_wait_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				tag_q       <= req_q.file_tag;
				total_q     <= start_count;
				base_q      <= '0;
				next_q      <= '0;
				base_slot_q <= '0;
				next_slot_q <= '0;
				active_q    <= 1'b1;
			end
			if (cmd.issue) begin
				next_q      <= next_q + CNT_W'(1);
				next_slot_q <= next_slot_inc;
			end
			if (cmd.slide) begin
				base_q      <= base_q + CNT_W'(1);
				base_slot_q <= base_slot_inc;
			end
			if (cmd.status_emit && (req_q.cmd == CMD_POLL) && (base_q == total_q)) begin
				active_q <= 1'b0;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_base_le_next: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= next_q) else $error("window base passed next sequence");
	a_window_span: assert property (@(posedge clk) disable iff (!arst_n)
		win_used <= WIN_CNT) else $error("more chunks outstanding than the window");
	a_next_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= total_q) else $error("issued past chunk count");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result register overwritten");
	a_slide_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slide |-> $past(cmd.rd_base)) else $error("slide without stamp read");

endmodule

// ----- design/nack_window_send_scheduler.sv -----
// ----------------------------------------------------------------------------
// nack_window_send_scheduler: sender window scheduler for NACK multicast
// A start request loads a tag and chunk count and answers with one status
// result, as does a poll while idle. A poll request on an open transfer
// issues new chunks (up to WINDOW), then sends a nack retransmit if one is
// asked for, then slides the base past each chunk that has timed out, each
// step a read of the stamp memory read port followed by the age compare,
// and stops at a chunk that is not yet old. Once every chunk has been
// issued, a tail age compare on the last chunk may resend it. Stalls on
// the result side hold the issue, nack, tail and status steps. The next
// request is taken while the last result waits.
// ----------------------------------------------------------------------------
module nack_window_send_scheduler #(
	parameter int WINDOW = nws_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  nws_pkg::req_item_t             req_item,
	output logic                           res_valid,
	input  logic                           res_ready,
	output nws_pkg::res_item_t             res_item,
	input  logic                           cfg_we,
	input  logic [nws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nws_pkg::CFG_W-1:0]      cfg_data
);
	import nws_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	nws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nws_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
